[rtl/hrac_pkg.sv]
// shared types and constants for the ramdac hidden register access core
package hrac_pkg;

  // i/o ports decoded by the front end
  localparam logic [15:0] PORT_HIDDEN = 16'h03c6;
  localparam logic [15:0] PORT_RD_IDX = 16'h03c7;
  localparam logic [15:0] PORT_WR_IDX = 16'h03c8;
  localparam logic [15:0] PORT_DATA   = 16'h03c9;

  // identification bytes answered at extended index 0 and 1
  localparam logic [7:0] ID_BYTE_0 = 8'h44;
  localparam logic [7:0] ID_BYTE_1 = 8'h02;

  // what the back end has to do with one access
  typedef enum logic [1:0] {
    KIND_HIDDEN_READ,
    KIND_HIDDEN_WRITE,
    KIND_CLEAR_STEP,
    KIND_OTHER
  } kind_e;

  // one classified access as it sits in the queue
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

endpackage

[rtl/hrac_ram.sv]
// generic single write port ram with registered read
module hrac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hrac_front.sv]
// front end: takes bus accesses and classifies them for the back end
module hrac_front
  import hrac_pkg::*;
(
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // io_address[15:0], write_data[23:16]
  input  logic        s_axis_tuser,  // mode: 0 read, 1 write
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic [15:0] addr;
  logic        is_write;

  assign addr     = s_axis_tdata[15:0];
  assign is_write = s_axis_tuser;

  always_comb begin
    item_o.data = s_axis_tdata[23:16];
    priority if (addr == PORT_HIDDEN) begin
      item_o.kind = is_write ? KIND_HIDDEN_WRITE : KIND_HIDDEN_READ;
    end else if (addr == PORT_WR_IDX || addr == PORT_DATA ||
                 (is_write && addr == PORT_RD_IDX)) begin
      item_o.kind = KIND_CLEAR_STEP;
    end else begin
      item_o.kind = KIND_OTHER;
    end
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

endmodule

[rtl/hrac_fifo.sv]
// two entry queue between front and back end
module hrac_fifo
  import hrac_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wptr_d  = push_i ? !wptr_q : wptr_q;
    rptr_d  = pop_i ? !rptr_q : rptr_q;
    count_d = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = mem_q[rptr_q];

endmodule

[rtl/hrac_back.sv]
// back end: unlock sequencer, command byte, extended index and registers
module hrac_back
  import hrac_pkg::*;
#(
  parameter int unsigned EXT_REG_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata  // read_data[7:0], forward_to_vga[8], pixel_depth[10:9]
);

  localparam int unsigned IDX_W = $clog2(EXT_REG_COUNT);

  localparam logic [2:0] STEP_CMD  = 3'd4;
  localparam logic [2:0] STEP_IDXL = 3'd5;
  localparam logic [2:0] STEP_IDXH = 3'd6;
  localparam logic [2:0] STEP_DATA = 3'd7;

  function automatic logic [2:0] read_next_plain(input logic [2:0] s);
    logic [2:0] n;
    unique case (s)
      3'd0:    n = 3'd1;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd3;
      3'd3:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] read_next_ext(input logic [2:0] s);
    return (s == STEP_DATA) ? STEP_DATA : s + 3'd1;
  endfunction

  function automatic logic [2:0] write_next(input logic [2:0] s);
    logic [2:0] n;
    unique case (s)
      STEP_IDXL: n = STEP_IDXH;
      STEP_IDXH: n = STEP_DATA;
      STEP_DATA: n = STEP_DATA;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] decode_depth(input logic [7:0] cmd, input logic [7:0] r3);
    logic [1:0] d;
    if (cmd[3]) begin
      unique case (r3)
        8'd1, 8'd2, 8'd8: d = 2'd1;
        8'd3, 8'd6:       d = 2'd2;
        8'd4, 8'd9:       d = 2'd3;
        default:          d = 2'd0;
      endcase
    end else begin
      unique case (cmd[7:5])
        3'd5:    d = 2'd1;
        3'd6:    d = 2'd2;
        3'd7:    d = 2'd3;
        default: d = 2'd0;
      endcase
    end
    return d;
  endfunction

  logic [2:0]               step_q, step_d;
  logic [7:0]               cmd_q, cmd_d;
  logic [15:0]              idx_q, idx_d;
  logic [7:0]               reg3_q, reg3_d;
  logic [1:0]               depth_q, depth_d;
  logic [EXT_REG_COUNT-1:0] vld_q, vld_d;
  logic                     out_vld_q;
  logic [15:0]              out_data_q;

  logic             fire;
  logic             in_range;
  logic [IDX_W-1:0] idx_lo;
  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic [7:0]       rd;
  logic             fwd;

  assign fire     = valid_i && (!out_vld_q || m_axis_tready);
  assign pop_o    = fire;
  assign in_range = {1'b0, idx_q} < 17'(EXT_REG_COUNT);
  assign idx_lo   = idx_q[IDX_W-1:0];

  always_comb begin
    step_d  = step_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    reg3_d  = reg3_q;
    depth_d = depth_q;
    vld_d   = vld_q;
    ram_we  = 1'b0;
    rd      = 8'hff;
    fwd     = 1'b1;
    if (fire) begin
      unique case (item_i.kind)
        KIND_HIDDEN_READ: begin
          fwd = 1'b0;
          unique case (step_q)
            STEP_CMD:  rd = cmd_q;
            STEP_IDXL: rd = idx_q[7:0];
            STEP_IDXH: rd = idx_q[15:8];
            STEP_DATA: begin
              priority if (idx_q == 16'd0) begin
                rd = ID_BYTE_0;
              end else if (idx_q == 16'd1) begin
                rd = ID_BYTE_1;
              end else if (in_range) begin
                rd = vld_q[idx_lo] ? ram_rdata : 8'h00;
              end else begin
                rd = 8'hff;
              end
              idx_d = idx_q + 16'd1;
            end
            default: rd = 8'hff;
          endcase
          step_d = cmd_q[4] ? read_next_ext(step_q) : read_next_plain(step_q);
        end
        KIND_HIDDEN_WRITE: begin
          fwd = step_q < STEP_CMD;
          unique case (step_q)
            STEP_CMD:  cmd_d = item_i.data;
            STEP_IDXL: idx_d = {idx_q[15:8], item_i.data};
            STEP_IDXH: idx_d = {item_i.data, idx_q[7:0]};
            STEP_DATA: begin
              if (in_range) begin
                ram_we        = 1'b1;
                vld_d[idx_lo] = 1'b1;
                if (idx_q == 16'd3) begin
                  reg3_d = item_i.data;
                end
              end
              idx_d = idx_q + 16'd1;
            end
            default: ;
          endcase
          step_d  = write_next(step_q);
          depth_d = decode_depth(cmd_d, reg3_d);
        end
        KIND_CLEAR_STEP: step_d = 3'd0;
        KIND_OTHER:      ;
        default:         ;
      endcase
    end
  end

  // read address follows the next index so the data is ready when needed
  hrac_ram #(
    .WIDTH (8),
    .DEPTH (EXT_REG_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_lo),
    .wdata_i (item_i.data),
    .raddr_i (idx_d[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= 3'd0;
      cmd_q     <= 8'h00;
      idx_q     <= 16'h0000;
      reg3_q    <= 8'h00;
      depth_q   <= 2'd0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      reg3_q  <= reg3_d;
      depth_q <= depth_d;
      vld_q   <= vld_d;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {5'd0, depth_d, fwd, rd};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/ramdac_hidden_register_access_core.sv]
// top level of the ramdac hidden register access core
//
// one bus access per transfer on the slave stream, one result per access on
// the master stream. the block sustains one access per clock while results
// are taken: the front end decodes the port and mode and drops the access
// into a two entry queue, the back end updates the unlock step, command byte,
// extended index and registers and loads the result register, so a result is
// offered once its access has passed through the queue and the result
// register. back pressure on the result side fills the queue, and the slave
// side stalls only once both entries are held. the extended registers live in
// a ram whose read is issued ahead on the next index; a valid bit per entry
// makes unwritten entries read as zero out of reset, with no clearing pass.
module ramdac_hidden_register_access_core
  import hrac_pkg::*;
#(
  parameter int unsigned EXT_REG_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // io_address[15:0], write_data[23:16]
  input  logic        s_axis_tuser,  // mode: 0 bus read, 1 bus write
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // read_data[7:0], forward_to_vga[8], pixel_depth[10:9]
);

  // classified access on its way into the queue
  logic  push;
  logic  full;
  item_t front_item;

  // head of the queue towards the back end
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // port decode and mode classification
  hrac_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  // decouples the two sides
  hrac_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // state update and result register
  hrac_back #(
    .EXT_REG_COUNT (EXT_REG_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[rtl/hrac_checker.sv]
// port level checks for the ramdac hidden register access core
module hrac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result holds its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // the access side stalls only while a result is held up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("access side stalled with no result pending");

  // a forwarded access is never answered by the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'hff)
    else $error("forwarded access carries read data");

  // depth only moves with a new result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata[10:9]))
    else $error("pixel depth changed under a stalled result");

endmodule

bind ramdac_hidden_register_access_core hrac_checker u_hrac_checker (.*);
